// ===== design/lss_pkg.sv =====
package lss_pkg;

    localparam int MAX_NEEDLE_DEF   = 32;
    localparam int MAX_HAYSTACK_DEF = 65536;

    localparam int NEEDLE_BYTES = 32;
    localparam int NUM_WORDS    = 4;
    localparam int NB_IDX_W     = $clog2(NEEDLE_BYTES);
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int LEN_CFG_W    = 6;
    localparam int POS_W        = 17;

    typedef logic [7:0] byte_t;
    typedef logic [POS_W-1:0] pos_t;
    typedef logic [LEN_CFG_W-1:0] len_cfg_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEEDLE_LENGTH = 3'd0,
        REG_NEEDLE_WORD_0 = 3'd1,
        REG_NEEDLE_WORD_1 = 3'd2,
        REG_NEEDLE_WORD_2 = 3'd3,
        REG_NEEDLE_WORD_3 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                 hit;
        logic [LEN_CFG_W:0]   len;
    } match_res_t;

endpackage

// ===== design/lss_in_if.sv =====
interface lss_in_if;
    import lss_pkg::*;

    logic  valid;
    logic  ready;
    byte_t hay_byte;
    logic  is_last;

    modport source (output valid, output hay_byte, output is_last, input ready);
    modport sink   (input valid, input hay_byte, input is_last, output ready);
endinterface

// ===== design/lss_out_if.sv =====
interface lss_out_if;
    import lss_pkg::*;

    logic valid;
    logic ready;
    logic found_first;
    pos_t first_offset;
    logic found_last;
    pos_t last_offset;
    logic too_long;

    modport source (
        output valid, output found_first, output first_offset,
        output found_last, output last_offset, output too_long,
        input ready
    );
    modport sink (
        input valid, input found_first, input first_offset,
        input found_last, input last_offset, input too_long,
        output ready
    );
endinterface

// ===== design/lss_match.sv =====
module lss_match #(
    parameter int MAX_NEEDLE = lss_pkg::MAX_NEEDLE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lss_pkg::len_cfg_t   pat_len,
    input  lss_pkg::byte_t      needle_bytes [lss_pkg::NEEDLE_BYTES],
    input  lss_pkg::byte_t      win [MAX_NEEDLE],
    output lss_pkg::match_res_t match
);
    import lss_pkg::*;

    localparam int LW = LEN_CFG_W + 1;

    logic [LW-1:0]         eff_len;
    byte_t                 al_next [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0] mask_next;

    logic [LW-1:0]         len_reg;
    byte_t                 al_reg [MAX_NEEDLE];
    logic [MAX_NEEDLE-1:0] mask_reg;
    logic [MAX_NEEDLE-1:0] eq;

    // effective length, clamped to 1..MAX_NEEDLE
    always_comb
    begin
        if (pat_len == '0)
            eff_len = LW'(1);
        else if ({1'b0, pat_len} > LW'(MAX_NEEDLE))
            eff_len = LW'(MAX_NEEDLE);
        else
            eff_len = {1'b0, pat_len};
    end

    // needle reversed so that window slot k (k = 0 newest) lines up with its byte
    always_comb
    begin
        logic [7:0] idx;
        idx = '0;
        for (int k = 0; k < MAX_NEEDLE; k++)
        begin
            idx          = 8'(eff_len) - 8'(k) - 8'd1;
            mask_next[k] = (8'(k) < 8'(eff_len));
            if (mask_next[k] && (idx < 8'(NEEDLE_BYTES)))
                al_next[k] = needle_bytes[idx[NB_IDX_W-1:0]];
            else
                al_next[k] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= LW'(1);
            mask_reg <= MAX_NEEDLE'(1);
            for (int k = 0; k < MAX_NEEDLE; k++)
                al_reg[k] <= '0;
        end
        else
        begin
            len_reg  <= eff_len;
            mask_reg <= mask_next;
            for (int k = 0; k < MAX_NEEDLE; k++)
                al_reg[k] <= al_next[k];
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_NEEDLE; k++)
            eq[k] = (win[k] == al_reg[k]);
    end

    assign match.hit = &(~mask_reg | eq);
    assign match.len = len_reg;

endmodule

// ===== design/literal_substring_search_unit.sv =====
// Streaming literal substring search. One haystack byte is taken per transfer, one per
// cycle sustained; the byte marked is_last closes the haystack and produces one result
// transfer carrying the first and last match offsets and the overflow flag. A byte goes
// through an input register; the window shift, the parallel compare of the whole needle
// window and the hit bookkeeping follow as it leaves that register, and a last byte then
// also loads the result register, from which the result is offered. Input is only
// held back when a last byte waits and the result register is still occupied. The
// needle is realigned into registers in the cycle after a write. No clearing pass.
module literal_substring_search_unit #(
    parameter int MAX_NEEDLE   = lss_pkg::MAX_NEEDLE_DEF,
    parameter int MAX_HAYSTACK = lss_pkg::MAX_HAYSTACK_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [lss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  lss_pkg::cfg_data_t               cfg_data,
    lss_in_if.sink                           hay,
    lss_out_if.source                        res
);
    import lss_pkg::*;

    localparam int CNT_W = $clog2(MAX_HAYSTACK + 1);
    localparam logic [CNT_W-1:0] HAY_LIMIT = CNT_W'(MAX_HAYSTACK);

    // configuration
    len_cfg_t  pat_len_reg;
    cfg_data_t needle_word_reg [NUM_WORDS];
    byte_t     needle_bytes [NEEDLE_BYTES];

    // input stage
    logic  a_valid_reg;
    byte_t a_byte_reg;
    logic  a_last_reg;

    // haystack state
    byte_t            win_reg [MAX_NEEDLE];
    byte_t            win_next [MAX_NEEDLE];
    logic [CNT_W-1:0] seen_reg;
    logic             first_valid_reg;
    logic [CNT_W-1:0] first_pos_reg;
    logic             last_valid_reg;
    logic [CNT_W-1:0] last_pos_reg;
    logic             ovf_reg;

    // result register
    logic res_valid_reg;
    logic found_first_reg;
    pos_t first_offset_reg;
    logic found_last_reg;
    pos_t last_offset_reg;
    logic too_long_reg;

    logic             advance;
    logic             accept_in;
    logic             beyond;
    logic [CNT_W-1:0] seen_next;
    logic [CNT_W-1:0] len_cnt;
    logic             hit;
    logic [CNT_W-1:0] pos;
    logic             first_valid_next;
    logic [CNT_W-1:0] first_pos_next;
    logic             last_valid_next;
    logic [CNT_W-1:0] last_pos_next;
    logic             ovf_next;
    match_res_t       match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg <= len_cfg_t'(1);
            for (int w = 0; w < NUM_WORDS; w++)
                needle_word_reg[w] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NEEDLE_LENGTH: pat_len_reg        <= cfg_data[LEN_CFG_W-1:0];
                REG_NEEDLE_WORD_0: needle_word_reg[0] <= cfg_data;
                REG_NEEDLE_WORD_1: needle_word_reg[1] <= cfg_data;
                REG_NEEDLE_WORD_2: needle_word_reg[2] <= cfg_data;
                REG_NEEDLE_WORD_3: needle_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < NEEDLE_BYTES; i++)
            needle_bytes[i] = needle_word_reg[i >> 3][8 * (i & 7) +: 8];
    end

    // handshake
    assign advance   = a_valid_reg && !(a_last_reg && res_valid_reg && !res.ready);
    assign hay.ready = !a_valid_reg || advance;
    assign accept_in = hay.valid && hay.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (accept_in)
            a_valid_reg <= 1'b1;
        else if (advance)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            a_byte_reg <= hay.hay_byte;
            a_last_reg <= hay.is_last;
        end
    end

    // window and compare
    always_comb
    begin
        win_next[0] = a_byte_reg;
        for (int k = 1; k < MAX_NEEDLE; k++)
            win_next[k] = win_reg[k-1];
    end

    lss_match #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_lss_match (
        .clk          (clk),
        .rst_n        (rst_n),
        .pat_len      (pat_len_reg),
        .needle_bytes (needle_bytes),
        .win          (win_next),
        .match        (match)
    );

    assign beyond    = (seen_reg == HAY_LIMIT);
    assign seen_next = beyond ? seen_reg : seen_reg + CNT_W'(1);
    assign len_cnt   = CNT_W'(match.len);
    assign hit       = match.hit && (seen_next >= len_cnt);
    assign pos       = beyond ? HAY_LIMIT : seen_next - len_cnt;

    assign first_valid_next = first_valid_reg || hit;
    assign first_pos_next   = first_valid_reg ? first_pos_reg : pos;
    assign last_valid_next  = last_valid_reg || hit;
    assign last_pos_next    = hit ? pos : last_pos_reg;
    assign ovf_next         = ovf_reg || beyond;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg        <= '0;
            first_valid_reg <= 1'b0;
            last_valid_reg  <= 1'b0;
            ovf_reg         <= 1'b0;
        end
        else if (advance)
        begin
            if (a_last_reg)
            begin
                seen_reg        <= '0;
                first_valid_reg <= 1'b0;
                last_valid_reg  <= 1'b0;
                ovf_reg         <= 1'b0;
            end
            else
            begin
                seen_reg        <= seen_next;
                first_valid_reg <= first_valid_next;
                last_valid_reg  <= last_valid_next;
                ovf_reg         <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < MAX_NEEDLE; k++)
                win_reg[k] <= win_next[k];
            first_pos_reg <= first_pos_next;
            last_pos_reg  <= last_pos_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance && a_last_reg)
            res_valid_reg <= 1'b1;
        else if (res.ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && a_last_reg)
        begin
            found_first_reg  <= first_valid_next;
            first_offset_reg <= first_valid_next ? POS_W'(first_pos_next) : POS_W'(seen_next);
            found_last_reg   <= last_valid_next;
            last_offset_reg  <= last_valid_next ? POS_W'(last_pos_next) : '0;
            too_long_reg     <= ovf_next;
        end
    end

    assign res.valid        = res_valid_reg;
    assign res.found_first  = found_first_reg;
    assign res.first_offset = first_offset_reg;
    assign res.found_last   = found_last_reg;
    assign res.last_offset  = last_offset_reg;
    assign res.too_long     = too_long_reg;

endmodule

// ===== design/lss_checker.sv =====
module lss_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          res_valid,
    input logic          res_ready,
    input logic          found_first,
    input lss_pkg::pos_t first_offset,
    input logic          found_last,
    input lss_pkg::pos_t last_offset,
    input logic          too_long
);
    import lss_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result transfer dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(first_offset) && $stable(last_offset)
            && $stable(found_first) && $stable(found_last) && $stable(too_long))
        else $error("result payload changed while stalled");

    a_found_agree: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> found_first == found_last)
        else $error("forward and reverse search disagree on a match");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found_last |-> last_offset == '0)
        else $error("reverse miss with nonzero offset");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && found_first && !too_long |-> first_offset <= last_offset)
        else $error("first match lies after last match");

endmodule

bind literal_substring_search_unit lss_checker u_lss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .found_first  (res.found_first),
    .first_offset (res.first_offset),
    .found_last   (res.found_last),
    .last_offset  (res.last_offset),
    .too_long     (res.too_long)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import lss_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HAY_LIMIT    = MAX_HAYSTACK_DEF;
    localparam int PHASE_BYTES  = 75;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef enum int {
        NEEDLE_RANDOM,
        NEEDLE_TWO_SYMBOL,
        NEEDLE_FLAT
    } needle_style_t;

    typedef struct packed {
        logic found_first;
        pos_t first_offset;
        logic found_last;
        pos_t last_offset;
        logic too_long;
    } report_t;

    class match_scoreboard;
        len_cfg_t  pat_len;
        cfg_data_t needle_word[NUM_WORDS];
        byte_t     window[NEEDLE_BYTES];
        int unsigned bytes_in;
        logic      first_hit;
        pos_t      first_pos;
        logic      last_hit;
        pos_t      last_pos;
        logic      overflow;
        report_t   reports_due[$];
        int        errors;

        function new();
            pat_len = len_cfg_t'(1);
            foreach (needle_word[i])
            begin
                needle_word[i] = '0;
            end
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (window[i])
            begin
                window[i] = '0;
            end
            bytes_in  = 0;
            first_hit = 0;
            first_pos = '0;
            last_hit  = 0;
            last_pos  = '0;
            overflow  = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, cfg_data_t value);
            case (idx)
                REG_NEEDLE_LENGTH: pat_len        = value[LEN_CFG_W-1:0];
                REG_NEEDLE_WORD_0: needle_word[0] = value;
                REG_NEEDLE_WORD_1: needle_word[1] = value;
                REG_NEEDLE_WORD_2: needle_word[2] = value;
                REG_NEEDLE_WORD_3: needle_word[3] = value;
                default: ;
            endcase
        endfunction

        function int unsigned span();
            if (pat_len == 0)
                return 1;
            if (pat_len > NEEDLE_BYTES)
                return NEEDLE_BYTES;
            return pat_len;
        endfunction

        function byte_t needle_at(int unsigned j);
            return needle_word[j / 8][(j % 8) * 8 +: 8];
        endfunction

        // one haystack byte; a report is due when it closes the haystack
        function void take_byte(byte_t b, logic last);
            bit beyond;
            bit hit;
            int unsigned n;
            int unsigned pos;
            int i;
            report_t r;
            beyond = bytes_in >= HAY_LIMIT;
            n = span();
            if (beyond)
                overflow = 1;
            else
                bytes_in++;
            for (i = NEEDLE_BYTES - 1; i > 0; i--)
            begin
                window[i] = window[i - 1];
            end
            window[0] = b;
            if (bytes_in >= n)
            begin
                hit = 1;
                for (i = 0; i < n; i++)
                begin
                    if (window[n - 1 - i] != needle_at(i))
                        hit = 0;
                end
                if (hit)
                begin
                    pos = beyond ? HAY_LIMIT : bytes_in - n;
                    if (!first_hit)
                    begin
                        first_hit = 1;
                        first_pos = pos_t'(pos);
                    end
                    last_hit = 1;
                    last_pos = pos_t'(pos);
                end
            end
            if (last)
            begin
                r.found_first  = first_hit;
                r.first_offset = first_hit ? first_pos : pos_t'(bytes_in);
                r.found_last   = last_hit;
                r.last_offset  = last_hit ? last_pos : '0;
                r.too_long     = overflow;
                reports_due.push_back(r);
                restart();
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (reports_due.size() == 0)
            begin
                $error("result transfer with no haystack pending");
                errors++;
                return;
            end
            want = reports_due.pop_front();
            compare_field("found_first", want.found_first, got.found_first);
            compare_field("first_offset", want.first_offset, got.first_offset);
            compare_field("found_last", want.found_last, got.found_last);
            compare_field("last_offset", want.last_offset, got.last_offset);
            compare_field("too_long", want.too_long, got.too_long);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    cfg_data_t            cfg_data;

    lss_in_if  hay_ch ();
    lss_out_if res_ch ();

    match_scoreboard board = new();

    bit hay_calm = 0;
    bit res_calm = 0;
    bit hay_rush = 0;
    int idle_cycles = 0;

    literal_substring_search_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hay       (hay_ch),
        .res       (res_ch)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic send_byte(byte_t b, logic last);
        int gap;
        gap = hay_rush ? 0 : draw_gap(hay_calm);
        if (gap > 0)
        begin
            hay_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hay_ch.valid    <= 1'b1;
        hay_ch.hay_byte <= b;
        hay_ch.is_last  <= last;
        do @(posedge clk); while (!hay_ch.ready);
        board.take_byte(b, last);
    endtask

    task automatic send_haystack(byte_t data[$]);
        foreach (data[i])
        begin
            send_byte(data[i], i == data.size() - 1);
        end
    endtask

    // hold the sender until every report is in and the pipeline is empty
    task automatic quiesce();
        hay_ch.valid <= 1'b0;
        do @(posedge clk); while (board.reports_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cfg_data_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        board.set_register(idx, value);
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
        repeat (2) @(posedge clk);
    endtask

    task automatic load_needle(int unsigned len, needle_style_t style);
        cfg_data_t w[NUM_WORDS];
        byte_t sym_a;
        byte_t sym_b;
        int j;
        sym_a = byte_t'($urandom);
        sym_b = byte_t'($urandom);
        for (j = 0; j < NEEDLE_BYTES; j++)
        begin
            case (style)
                NEEDLE_RANDOM:     w[j / 8][(j % 8) * 8 +: 8] = byte_t'($urandom);
                NEEDLE_TWO_SYMBOL: w[j / 8][(j % 8) * 8 +: 8] =
                                       $urandom_range(0, 1) ? sym_b : sym_a;
                default:           w[j / 8][(j % 8) * 8 +: 8] = sym_a;
            endcase
        end
        write_reg(REG_NEEDLE_LENGTH, cfg_data_t'(len));
        write_reg(REG_NEEDLE_WORD_0, w[0]);
        write_reg(REG_NEEDLE_WORD_1, w[1]);
        write_reg(REG_NEEDLE_WORD_2, w[2]);
        write_reg(REG_NEEDLE_WORD_3, w[3]);
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                      {$urandom, $urandom});
        close_writes();
    endtask

    // mostly haystacks seeded with needle bytes and whole needle copies
    task automatic random_haystack(output int unsigned n);
        byte_t data[$];
        int unsigned width;
        int unsigned at;
        bit planted;
        int i;
        width = board.span();
        planted = $urandom_range(0, 9) < 7;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3 * width + 10)
                                        : $urandom_range(1, width + 8);
        for (i = 0; i < n; i++)
        begin
            if (planted && $urandom_range(0, 7) != 0)
                data.push_back(board.needle_at($urandom_range(0, width - 1)));
            else
                data.push_back(byte_t'($urandom));
        end
        if (planted && n >= width)
        begin
            repeat ($urandom_range(1, 3))
            begin
                at = $urandom_range(0, n - width);
                for (i = 0; i < width; i++)
                begin
                    data[at + i] = board.needle_at(i);
                end
            end
        end
        send_haystack(data);
    endtask

    // past the length limit; optional matches straddle the saturation point
    task automatic send_long(int unsigned n, bit marks);
        byte_t b;
        int unsigned i;
        for (i = 0; i < n; i++)
        begin
            b = 8'h00;
            if (marks && (i == 10 || i == HAY_LIMIT - 2 || i == HAY_LIMIT))
                b = 8'h5A;
            if (marks && (i == 11 || i == HAY_LIMIT - 1 || i == HAY_LIMIT + 1))
                b = 8'hA5;
            send_byte(b, i == n - 1);
        end
    endtask

    initial
    begin
        report_t got;
        int stall;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap(res_calm);
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            got.found_first  = res_ch.found_first;
            got.first_offset = res_ch.first_offset;
            got.found_last   = res_ch.found_last;
            got.last_offset  = res_ch.last_offset;
            got.too_long     = res_ch.too_long;
            board.check_report(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (hay_ch.valid && hay_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        byte_t hay[$];
        int lens[8];
        int unsigned n;
        int unsigned sent;
        int p;
        hay_ch.valid    <= 1'b0;
        hay_ch.hay_byte <= '0;
        hay_ch.is_last  <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset needle: one zero byte
        hay = '{8'h00};
        send_haystack(hay);
        hay = '{8'hFF, 8'h00, 8'h00, 8'h7F};
        send_haystack(hay);

        quiesce();
        write_reg(REG_NEEDLE_LENGTH, cfg_data_t'(3));
        write_reg(REG_NEEDLE_WORD_0, 64'h0000_0000_00FF_0041);
        write_reg(REG_NEEDLE_WORD_1, {$urandom, $urandom});
        write_reg(REG_NEEDLE_WORD_2, {$urandom, $urandom});
        write_reg(REG_NEEDLE_WORD_3, {$urandom, $urandom});
        close_writes();
        hay = '{8'h41, 8'h00};
        send_haystack(hay);
        hay = '{8'h41, 8'h00, 8'hFF, 8'h41, 8'h00, 8'hFF};
        send_haystack(hay);

        // zero length acts as one, 63 as the maximum
        quiesce();
        write_reg(REG_NEEDLE_LENGTH, cfg_data_t'(0));
        close_writes();
        hay = '{8'h00, 8'h41};
        send_haystack(hay);

        quiesce();
        write_reg(REG_NEEDLE_LENGTH, cfg_data_t'(63));
        write_reg(REG_SPARE_FIRST, '1);
        write_reg(REG_SPARE_LAST, {$urandom, $urandom});
        close_writes();
        hay = '{8'h41, 8'h00};
        send_haystack(hay);

        // needle rewritten between bytes of one haystack
        quiesce();
        write_reg(REG_NEEDLE_LENGTH, cfg_data_t'(2));
        write_reg(REG_NEEDLE_WORD_0, 64'h2211);
        close_writes();
        send_byte(8'h11, 1'b0);
        quiesce();
        write_reg(REG_NEEDLE_WORD_0, 64'h4411);
        close_writes();
        send_byte(8'h44, 1'b1);

        quiesce();
        write_reg(REG_NEEDLE_WORD_0, 64'hA55A);
        close_writes();
        hay_rush = 1;
        send_long(HAY_LIMIT + 4, 1'b1);
        send_long(HAY_LIMIT + 2, 1'b0);
        hay_rush = 0;

        lens = '{1, 32, 0, 63, 0, 0, 0, 0};
        for (p = 4; p < 8; p++)
        begin
            lens[p] = $urandom_range(2, 31);
        end
        for (p = 0; p < 8; p++)
        begin
            quiesce();
            load_needle(lens[p], (p == 0) ? NEEDLE_RANDOM
                                          : needle_style_t'($urandom_range(0, 2)));
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                random_haystack(n);
                sent += n;
                if ($urandom_range(0, 7) == 0)
                    quiesce();
            end
        end

        quiesce();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== files.f =====
design/lss_pkg.sv
design/lss_in_if.sv
design/lss_out_if.sv
design/lss_match.sv
design/literal_substring_search_unit.sv
design/lss_checker.sv
bench/tb.sv
